// ----- rtl/vrp_pkg.sv -----
// Shared types and constants for the vertex rotate and project block.
// Depends on nothing; every rtl file refers to it by scoped names.
`default_nettype none

package vrp_pkg;

  // One input word: model-space vertex, signed fixed point
  typedef struct packed {
    logic signed [15:0] vertex_z;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_x;
  } in_t;

  // One result word
  typedef struct packed {
    logic               behind_viewer;
    logic signed [15:0] screen_y;
    logic signed [15:0] screen_x;
  } out_t;

  // Configuration register file
  typedef struct packed {
    logic signed [15:0] cos_about_y;
    logic signed [15:0] sin_about_y;
    logic signed [15:0] cos_about_x;
    logic signed [15:0] sin_about_x;
    logic [14:0]        focal_distance;
    logic [15:0]        zoom;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
  } cfg_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_Y  = 3'd0,
    CFG_SIN_Y  = 3'd1,
    CFG_COS_X  = 3'd2,
    CFG_SIN_X  = 3'd3,
    CFG_FOCAL  = 3'd4,
    CFG_ZOOM   = 3'd5,
    CFG_CTR_X  = 3'd6,
    CFG_CTR_Y  = 3'd7
  } cfg_idx_e;

  localparam cfg_t CFG_RESET = '{
    cos_about_y:    16'sd16384,
    sin_about_y:    16'sd0,
    cos_about_x:    16'sd16384,
    sin_about_x:    16'sd0,
    focal_distance: 15'd256,
    zoom:           16'd256,
    center_x:       12'd320,
    center_y:       12'd240
  };

  // zoom is Q8.8
  localparam int unsigned ZOOM_FRAC_BITS = 8;
  // quotient bits resolved by the divider; anything larger saturates anyway
  localparam int unsigned QUOT_BITS = 18;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

endpackage

`default_nettype wire

// ----- rtl/vrp_front.sv -----
// Front pipe: takes vertices and applies the Y then X rotations, five stages.
// Depends on vrp_pkg. Emits a packed word {behind, den, y2, x2} to the queue.
`default_nettype none

module vrp_front #(
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vrp_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire vrp_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [(1 + (51 - 2*TRIG_FRAC_BITS)) + (50 - 2*TRIG_FRAC_BITS)
                + (33 - TRIG_FRAC_BITS) - 1:0] out_data_o
);

  localparam int unsigned T   = TRIG_FRAC_BITS;
  localparam int unsigned X1W = 33 - T;          // x1, z1, x2
  localparam int unsigned P2W = 16 + X1W;        // second rotation products
  localparam int unsigned Y2W = P2W + 1 - T;     // y2, z2
  localparam int unsigned DW  = Y2W + 1;         // denominator

  localparam logic [32:0]  BIAS1 = (33'd1 << T) - 33'd1;
  localparam logic [P2W:0] BIAS2 = ((P2W+1)'(1) << T) - (P2W+1)'(1);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en;

  logic signed [15:0] vx_q, vy_q, vz_q;
  logic signed [31:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [15:0] vy2_q;
  logic signed [X1W-1:0] x1_q, y1_q, z1_q;
  logic signed [P2W-1:0] qa_q, qb_q, qc_q, qd_q;
  logic signed [X1W-1:0] x2_q;
  logic [X1W-1:0] x2_o_q;
  logic [Y2W-1:0] y2_o_q;
  logic [DW-1:0]  den_o_q;
  logic           behind_o_q;

  logic [32:0]  sa, sc, ta, tc;
  logic [P2W:0] sy, sz, ty, tz;
  logic [Y2W-1:0] y2, z2;
  logic [DW-1:0]  den;

  assign en         = !(v5_q && out_stall_i);
  assign in_stall_o = !en;

  // first rotation, truncating toward zero
  assign sa = {pa_q[31], pa_q} - {pb_q[31], pb_q};
  assign sc = {pc_q[31], pc_q} + {pd_q[31], pd_q};
  assign ta = sa + (sa[32] ? BIAS1 : 33'd0);
  assign tc = sc + (sc[32] ? BIAS1 : 33'd0);

  // second rotation
  assign sy = {qa_q[P2W-1], qa_q} - {qb_q[P2W-1], qb_q};
  assign sz = {qc_q[P2W-1], qc_q} + {qd_q[P2W-1], qd_q};
  assign ty = sy + (sy[P2W] ? BIAS2 : '0);
  assign tz = sz + (sz[P2W] ? BIAS2 : '0);
  assign y2 = ty[P2W:T];
  assign z2 = tz[P2W:T];

  assign den = {{(DW-15){1'b0}}, cfg_i.focal_distance} + {z2[Y2W-1], z2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q  <= in_data_i.vertex_x;
      vy_q  <= in_data_i.vertex_y;
      vz_q  <= in_data_i.vertex_z;

      pa_q  <= cfg_i.cos_about_y * vx_q;
      pb_q  <= cfg_i.sin_about_y * vz_q;
      pc_q  <= cfg_i.sin_about_y * vx_q;
      pd_q  <= cfg_i.cos_about_y * vz_q;
      vy2_q <= vy_q;

      x1_q  <= ta[32:T];
      z1_q  <= tc[32:T];
      y1_q  <= {{(X1W-16){vy2_q[15]}}, vy2_q};

      qa_q  <= cfg_i.cos_about_x * y1_q;
      qb_q  <= cfg_i.sin_about_x * z1_q;
      qc_q  <= cfg_i.sin_about_x * y1_q;
      qd_q  <= cfg_i.cos_about_x * z1_q;
      x2_q  <= x1_q;

      x2_o_q     <= x2_q;
      y2_o_q     <= y2;
      den_o_q    <= den;
      behind_o_q <= den[DW-1] || (den == '0);
    end
  end

  assign out_valid_o = v5_q;
  assign out_data_o  = {behind_o_q, den_o_q, y2_o_q, x2_o_q};

endmodule

`default_nettype wire

// ----- rtl/vrp_fifo.sv -----
// Short register queue between the rotation and projection pipes.
// Depends on vrp_pkg for depth constants.
`default_nettype none

module vrp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WIDTH-1:0]      out_data_o
);

  logic [WIDTH-1:0] mem_q [vrp_pkg::FIFO_DEPTH];
  logic [vrp_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [vrp_pkg::FIFO_PTR_W:0]   cnt_q;
  logic full, push, pop;

  assign full        = (cnt_q == (vrp_pkg::FIFO_PTR_W+1)'(vrp_pkg::FIFO_DEPTH));
  assign push        = in_valid_i && !full;
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = full;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

endmodule

`default_nettype wire

// ----- rtl/vrp_back.sv -----
// Back pipe: perspective scale, pipelined restoring divide, centre and saturate.
// Depends on vrp_pkg. Takes queue words from vrp_front's format.
`default_nettype none

module vrp_back #(
  parameter int unsigned COORD_FRAC_BITS = 8,
  parameter int unsigned TRIG_FRAC_BITS  = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vrp_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [(1 + (51 - 2*TRIG_FRAC_BITS)) + (50 - 2*TRIG_FRAC_BITS)
                     + (33 - TRIG_FRAC_BITS) - 1:0] in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output vrp_pkg::out_t      out_data_o
);

  localparam int unsigned T    = TRIG_FRAC_BITS;
  localparam int unsigned X1W  = 33 - T;
  localparam int unsigned P2W  = 16 + X1W;
  localparam int unsigned Y2W  = P2W + 1 - T;
  localparam int unsigned DW   = Y2W + 1;
  localparam int unsigned RW   = DW;                       // remainder
  localparam int unsigned QB   = vrp_pkg::QUOT_BITS;
  localparam int unsigned S    = COORD_FRAC_BITS + vrp_pkg::ZOOM_FRAC_BITS;
  localparam int unsigned MXW  = 31 + X1W;
  localparam int unsigned MYW  = 31 + Y2W;
  localparam int unsigned NX   = MXW - S;                  // dividend widths
  localparam int unsigned NY   = MYW - S;
  localparam int unsigned CXW  = NX - QB + RW;
  localparam int unsigned CYW  = NY - QB + RW;
  localparam int unsigned SUMW = QB + 2;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(32767);
  localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(-32768);

  typedef struct packed {
    logic          behind;
    logic          neg_x;
    logic          neg_y;
    logic          ovf_x;
    logic          ovf_y;
    logic [RW-2:0] den;
    logic [QB-1:0] lo_x;
    logic [QB-1:0] lo_y;
    logic [QB-1:0] qt_x;
    logic [QB-1:0] qt_y;
    logic [RW-1:0] rm_x;
    logic [RW-1:0] rm_y;
  } dstg_t;

  logic en;
  logic v1_q, v2_q, out_valid_q;
  logic [QB:0] vd_q;

  // unpack queue word
  logic [X1W-1:0] in_x2;
  logic [Y2W-1:0] in_y2;
  logic [DW-1:0]  in_den;
  logic           in_behind;

  logic [X1W-1:0] ax_q;
  logic [Y2W-1:0] ay_q;
  logic [30:0]    fz_q;
  logic           nx1_q, ny1_q, bh1_q;
  logic [RW-2:0]  den1_q;

  logic [MXW-1:0] mx_q;
  logic [MYW-1:0] my_q;
  logic           nx2_q, ny2_q, bh2_q;
  logic [RW-2:0]  den2_q;

  logic [NX-1:0]  dx;
  logic [NY-1:0]  dy;
  logic [NX-QB-1:0] hx;
  logic [NY-QB-1:0] hy;

  dstg_t dst_q [QB+1];
  vrp_pkg::out_t out_q;

  function automatic logic signed [15:0] place(
    input logic [11:0]    ctr,
    input logic [QB-1:0]  qt,
    input logic           neg,
    input logic           ovf
  );
    logic signed [SUMW-1:0] mag;
    logic signed [SUMW-1:0] sum;
    logic signed [15:0]     res;
    mag = SUMW'(qt);
    sum = SUMW'(ctr) + (neg ? -mag : mag);
    if (ovf)                res = neg ? 16'sh8000 : 16'sh7fff;
    else if (sum > SAT_HI)  res = 16'sh7fff;
    else if (sum < SAT_LO)  res = 16'sh8000;
    else                    res = sum[15:0];
    return res;
  endfunction

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_x2     = in_data_i[X1W-1:0];
  assign in_y2     = in_data_i[X1W+Y2W-1:X1W];
  assign in_den    = in_data_i[X1W+Y2W+DW-1:X1W+Y2W];
  assign in_behind = in_data_i[X1W+Y2W+DW];

  assign dx = mx_q[MXW-1:S];
  assign dy = my_q[MYW-1:S];
  assign hx = dx[NX-1:QB];
  assign hy = dy[NY-1:QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      vd_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      vd_q        <= {vd_q[QB-1:0], v2_q};
      out_valid_q <= vd_q[QB];
    end
  end

  // magnitudes and fov*zoom
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= in_x2[X1W-1] ? (~in_x2 + 1'b1) : in_x2;
      ay_q   <= in_y2[Y2W-1] ? (~in_y2 + 1'b1) : in_y2;
      nx1_q  <= in_x2[X1W-1];
      ny1_q  <= in_y2[Y2W-1];
      bh1_q  <= in_behind;
      den1_q <= in_den[DW-2:0];
      fz_q   <= cfg_i.focal_distance * cfg_i.zoom;

      mx_q   <= fz_q * ax_q;
      my_q   <= fz_q * ay_q;
      nx2_q  <= nx1_q;
      ny2_q  <= ny1_q;
      bh2_q  <= bh1_q;
      den2_q <= den1_q;

      // divider set-up: high dividend part is the first partial remainder
      dst_q[0].behind <= bh2_q;
      dst_q[0].neg_x  <= nx2_q;
      dst_q[0].neg_y  <= ny2_q;
      dst_q[0].ovf_x  <= CXW'(hx) >= CXW'(den2_q);
      dst_q[0].ovf_y  <= CYW'(hy) >= CYW'(den2_q);
      dst_q[0].den    <= den2_q;
      dst_q[0].lo_x   <= dx[QB-1:0];
      dst_q[0].lo_y   <= dy[QB-1:0];
      dst_q[0].qt_x   <= '0;
      dst_q[0].qt_y   <= '0;
      dst_q[0].rm_x   <= RW'(hx);
      dst_q[0].rm_y   <= RW'(hy);
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [RW-1:0] shx, shy;
    logic          gex, gey;
    assign shx = {dst_q[i].rm_x[RW-2:0], dst_q[i].lo_x[QB-1]};
    assign shy = {dst_q[i].rm_y[RW-2:0], dst_q[i].lo_y[QB-1]};
    assign gex = shx >= {1'b0, dst_q[i].den};
    assign gey = shy >= {1'b0, dst_q[i].den};

    always_ff @(posedge clk_i) begin
      if (en) begin
        dst_q[i+1].behind <= dst_q[i].behind;
        dst_q[i+1].neg_x  <= dst_q[i].neg_x;
        dst_q[i+1].neg_y  <= dst_q[i].neg_y;
        dst_q[i+1].ovf_x  <= dst_q[i].ovf_x;
        dst_q[i+1].ovf_y  <= dst_q[i].ovf_y;
        dst_q[i+1].den    <= dst_q[i].den;
        dst_q[i+1].lo_x   <= {dst_q[i].lo_x[QB-2:0], 1'b0};
        dst_q[i+1].lo_y   <= {dst_q[i].lo_y[QB-2:0], 1'b0};
        dst_q[i+1].qt_x   <= {dst_q[i].qt_x[QB-2:0], gex};
        dst_q[i+1].qt_y   <= {dst_q[i].qt_y[QB-2:0], gey};
        dst_q[i+1].rm_x   <= gex ? (shx - {1'b0, dst_q[i].den}) : shx;
        dst_q[i+1].rm_y   <= gey ? (shy - {1'b0, dst_q[i].den}) : shy;
      end
    end
  end

  // centre, saturate, or park at the centre when behind the viewer
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.behind_viewer <= dst_q[QB].behind;
      if (dst_q[QB].behind) begin
        out_q.screen_x <= {4'd0, cfg_i.center_x};
        out_q.screen_y <= {4'd0, cfg_i.center_y};
      end else begin
        out_q.screen_x <= place(cfg_i.center_x, dst_q[QB].qt_x,
                                dst_q[QB].neg_x, dst_q[QB].ovf_x);
        out_q.screen_y <= place(cfg_i.center_y, dst_q[QB].qt_y,
                                dst_q[QB].neg_y, dst_q[QB].ovf_y);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vertex_rotate_project.sv -----
// Vertex rotate and project, top level. One vertex word in per cycle when
// nothing stalls; one result word out per vertex, in order, after the
// rotation pipe, the queue and the projection pipe. Throughput is set by the
// two fully pipelined halves: every multiplier and each divider bit has its
// own stage, so a new vertex is taken every cycle unless a stall holds it.
// The rotation and projection pipes stall independently; a four-word queue
// sits between them. Configuration is to be written only while idle; the
// block does not enforce this, and cfg_ready_o is always high.
// Depends on vrp_pkg, vrp_front, vrp_fifo and vrp_back.
`default_nettype none

module vertex_rotate_project #(
  parameter int unsigned COORD_FRAC_BITS = 8,
  parameter int unsigned TRIG_FRAC_BITS  = 14
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // vertex word in
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire vrp_pkg::in_t                       in_data_i,
  // result word out
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output vrp_pkg::out_t                           out_data_o,
  // register writes
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [vrp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [vrp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // queue word: {behind, denominator, rotated y, rotated x}
  localparam int unsigned EW = (1 + (51 - 2*TRIG_FRAC_BITS))
                               + (50 - 2*TRIG_FRAC_BITS) + (33 - TRIG_FRAC_BITS);

  vrp_pkg::cfg_t cfg_q;

  logic          f_valid, f_stall;
  logic [EW-1:0] f_data;
  logic          b_valid, b_stall;
  logic [EW-1:0] b_data;

  assign cfg_ready_o = 1'b1;

  // register file: to be written only between bursts (the block does not enforce this), so no shadowing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= vrp_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vrp_pkg::CFG_COS_Y: cfg_q.cos_about_y    <= cfg_data_i;
        vrp_pkg::CFG_SIN_Y: cfg_q.sin_about_y    <= cfg_data_i;
        vrp_pkg::CFG_COS_X: cfg_q.cos_about_x    <= cfg_data_i;
        vrp_pkg::CFG_SIN_X: cfg_q.sin_about_x    <= cfg_data_i;
        vrp_pkg::CFG_FOCAL: cfg_q.focal_distance <= cfg_data_i[14:0];
        vrp_pkg::CFG_ZOOM:  cfg_q.zoom           <= cfg_data_i;
        vrp_pkg::CFG_CTR_X: cfg_q.center_x       <= cfg_data_i[11:0];
        vrp_pkg::CFG_CTR_Y: cfg_q.center_y       <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // rotation about Y then X, denominator and behind-viewer test
  vrp_front #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (f_valid),
    .out_stall_i (f_stall),
    .out_data_o  (f_data)
  );

  // decoupling queue
  vrp_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_stall_o  (f_stall),
    .in_data_i   (f_data),
    .out_valid_o (b_valid),
    .out_stall_i (b_stall),
    .out_data_o  (b_data)
  );

  // fov*zoom scaling, divide by the denominator, centre and saturate
  vrp_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (b_valid),
    .in_stall_o  (b_stall),
    .in_data_i   (b_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a vertex behind the viewer lands on the centre
  a_behind_ctr_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.behind_viewer
      |-> out_data_o.screen_x == {4'd0, cfg_q.center_x})
    else $error("behind-viewer word not at centre x");

  a_behind_ctr_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.behind_viewer
      |-> out_data_o.screen_y == {4'd0, cfg_q.center_y})
    else $error("behind-viewer word not at centre y");

  // zero zoom collapses every projection onto the centre
  a_zoom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cfg_q.zoom == '0)
      |-> out_data_o.screen_x == {4'd0, cfg_q.center_x}
       && out_data_o.screen_y == {4'd0, cfg_q.center_y})
    else $error("zero zoom gave an off-centre word");

endmodule

`default_nettype wire

// ----- tb/sv/vertex_rotate_project_tb.sv -----
// Self-checking testbench for vertex_rotate_project: vertex words are driven in,
// and result words are checked against a predictor of the rotation and projection.
// Depends on vrp_pkg and the vertex_rotate_project RTL.
`default_nettype none

module vertex_rotate_project_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point scaling used by the projection
  localparam longint TRIG_ONE  = 64'sd16384;   // 2^TRIG_FRAC_BITS
  localparam longint PROJ_DIV  = 64'sd65536;   // 2^(COORD_FRAC_BITS + ZOOM_FRAC_BITS)
  localparam int     DRAIN_CYC = 40;
  localparam longint CYCLE_LIM = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  vrp_pkg::in_t      in_data;
  logic              out_valid;
  logic              out_stall;
  vrp_pkg::out_t     out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  vrp_pkg::cfg_idx_e cfg_index;
  logic [15:0]       cfg_data;

  vertex_rotate_project u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Register image as the block should hold it
  vrp_pkg::cfg_t view_cfg = vrp_pkg::CFG_RESET;
  vrp_pkg::in_t  vertex_backlog[$];
  vrp_pkg::out_t screen_expected[$];
  int     words_queued   = 0;
  int     words_taken    = 0;
  int     mismatch_count = 0;
  logic   in_taken       = 1'b0;
  logic   idle_on        = 1'b1;
  int     gap_left       = 0;
  int     stall_left     = 0;
  longint cycle_count    = 0;

  // Clock: 20 ns period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Rotate about Y, then X, then project; every division truncates toward zero
  function automatic vrp_pkg::out_t project_vertex(vrp_pkg::in_t v, vrp_pkg::cfg_t c);
    longint cy, sy, cx, sx, fov, zm, vx, vy, vz;
    longint x1, z1, y2, z2, den, px, py;
    vrp_pkg::out_t r;
    cy  = c.cos_about_y;
    sy  = c.sin_about_y;
    cx  = c.cos_about_x;
    sx  = c.sin_about_x;
    fov = c.focal_distance;
    zm  = c.zoom;
    vx  = v.vertex_x;
    vy  = v.vertex_y;
    vz  = v.vertex_z;
    x1  = (cy * vx - sy * vz) / TRIG_ONE;
    z1  = (sy * vx + cy * vz) / TRIG_ONE;
    y2  = (cx * vy - sx * z1) / TRIG_ONE;
    z2  = (sx * vy + cx * z1) / TRIG_ONE;
    den = fov + z2;
    if (den <= 0) begin
      // on or behind the viewer plane: centre is reported
      r.screen_x      = clamp16(longint'(c.center_x));
      r.screen_y      = clamp16(longint'(c.center_y));
      r.behind_viewer = 1'b1;
    end else begin
      px = (fov * x1 * zm) / (den * PROJ_DIV);
      py = (fov * y2 * zm) / (den * PROJ_DIV);
      r.screen_x      = clamp16(longint'(c.center_x) + px);
      r.screen_y      = clamp16(longint'(c.center_y) + py);
      r.behind_viewer = 1'b0;
    end
    return r;
  endfunction

  // Sender: one vertex word per handshake, bursts of idle cycles in between
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 7);
      end else if (vertex_backlog.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= vertex_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Accepted vertices get their prediction; accepted results are checked
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken    <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      screen_expected.push_back(project_vertex(in_data, view_cfg));
      words_taken <= words_taken + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (screen_expected.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        mismatch_count = mismatch_count + 1;
      end else begin
        automatic vrp_pkg::out_t want = screen_expected.pop_front();
        if (out_data.screen_x !== want.screen_x) begin
          $error("screen_x: expected %0d, got %0d", want.screen_x, out_data.screen_x);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.screen_y !== want.screen_y) begin
          $error("screen_y: expected %0d, got %0d", want.screen_y, out_data.screen_y);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.behind_viewer !== want.behind_viewer) begin
          $error("behind_viewer: expected %0b, got %0b",
                 want.behind_viewer, out_data.behind_viewer);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIM) begin
      $display("vertex_rotate_project_tb: done, errors");
      $finish;
    end
  end

  // Register write; image updated on the handshake edge
  task automatic write_reg(vrp_pkg::cfg_idx_e idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      vrp_pkg::CFG_COS_Y: view_cfg.cos_about_y    = data;
      vrp_pkg::CFG_SIN_Y: view_cfg.sin_about_y    = data;
      vrp_pkg::CFG_COS_X: view_cfg.cos_about_x    = data;
      vrp_pkg::CFG_SIN_X: view_cfg.sin_about_x    = data;
      vrp_pkg::CFG_FOCAL: view_cfg.focal_distance = data[14:0];
      vrp_pkg::CFG_ZOOM:  view_cfg.zoom           = data;
      vrp_pkg::CFG_CTR_X: view_cfg.center_x       = data[11:0];
      vrp_pkg::CFG_CTR_Y: view_cfg.center_y       = data[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_view(logic [15:0] cy, logic [15:0] sy, logic [15:0] cx,
                            logic [15:0] sx, logic [15:0] fov, logic [15:0] zm,
                            logic [15:0] ctx, logic [15:0] cty);
    write_reg(vrp_pkg::CFG_COS_Y, cy);
    write_reg(vrp_pkg::CFG_SIN_Y, sy);
    write_reg(vrp_pkg::CFG_COS_X, cx);
    write_reg(vrp_pkg::CFG_SIN_X, sx);
    write_reg(vrp_pkg::CFG_FOCAL, fov);
    write_reg(vrp_pkg::CFG_ZOOM, zm);
    write_reg(vrp_pkg::CFG_CTR_X, ctx);
    write_reg(vrp_pkg::CFG_CTR_Y, cty);
  endtask

  task automatic queue_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    vrp_pkg::in_t v;
    v.vertex_x = x;
    v.vertex_y = y;
    v.vertex_z = z;
    vertex_backlog.push_back(v);
    words_queued++;
  endtask

  // Mix of full-range words and small ones that land near the viewer
  function automatic logic [15:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return 16'($urandom_range(0, 4095) - 2048);
    if (sel == 2) return 16'($urandom_range(0, 255) - 128);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  function automatic logic [15:0] rand_trig();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 16'h4000;
    if (sel == 1) return 16'hc000;
    if (sel == 2) return 16'h0000;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // Let everything drain; the sender is held until the last result is back
  task automatic drain();
    while (words_taken != words_queued) @(posedge clk);
    while (screen_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = vrp_pkg::CFG_COS_Y;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset view: field extremes, viewer plane, behind, saturation
    queue_vertex(16'h0000, 16'h0000, 16'h0000);
    queue_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    queue_vertex(16'h8000, 16'h8000, 16'h7fff);
    queue_vertex(16'h7fff, 16'h8000, 16'hff01);   // den = 1, saturates
    queue_vertex(16'h8000, 16'h7fff, 16'hff01);
    queue_vertex(16'h0100, 16'h0100, 16'hff00);   // den = 0, on the viewer plane
    queue_vertex(16'h0100, 16'h0100, 16'h8000);   // behind
    queue_vertex(16'hffff, 16'hffff, 16'hffff);
    queue_vertex(16'h5555, 16'haaaa, 16'h0100);
    queue_vertex(16'haaaa, 16'h5555, 16'h0000);
    drain();

    // Trig out of range, centre and zoom extremes
    write_view(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'hffff,
               16'h0fff, 16'h0fff);
    queue_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    queue_vertex(16'h8000, 16'h8000, 16'h8000);
    queue_vertex(16'h7fff, 16'h8000, 16'h8000);
    queue_vertex(16'h0010, 16'hfff0, 16'h0000);
    drain();

    // Zero focal distance (bit 15 of the data is dropped), zoom and centre at 0
    write_view(16'hc000, 16'h4000, 16'h4000, 16'hc000, 16'h8000, 16'h0000,
               16'hf000, 16'h0000);
    queue_vertex(16'h1234, 16'h8000, 16'h7fff);
    queue_vertex(16'h1234, 16'h8000, 16'h8000);
    drain();
    write_reg(vrp_pkg::CFG_ZOOM, 16'hffff);
    queue_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    queue_vertex(16'h0000, 16'h0000, 16'h8000);
    drain();

    // Random phases; the last one runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) idle_on = 1'b0;
      write_view(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(1, 2048)),
                 ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(64, 1024)),
                 16'($urandom), 16'($urandom));
      repeat (72) queue_vertex(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    if (mismatch_count == 0) begin
      $display("vertex_rotate_project_tb: done, clean");
    end else begin
      $display("vertex_rotate_project_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/vrp_pkg.sv
rtl/vrp_front.sv
rtl/vrp_fifo.sv
rtl/vrp_back.sv
rtl/vertex_rotate_project.sv
tb/sv/vertex_rotate_project_tb.sv
